>>> rtl/core/rtpk_pkg.sv
// Shared types and constants for the H.264 RTP packetizer.
// No dependencies; compiled first.

package rtpk_pkg;

   // RTP header and FU-A constants
   localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
   localparam logic [4:0] FU_A_TYPE = 5'd28;
   localparam logic [7:0] NAL_FNRI_MASK = 8'he0;
   localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
   localparam logic [11:0] MIN_LIMIT = 12'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_TIMESTAMP_STEP = 2'd0;
   localparam logic [1:0] CSR_SYNC_SOURCE_ID = 2'd1;
   localparam logic [1:0] CSR_PAYLOAD_KIND = 2'd2;
   localparam logic [1:0] CSR_PAYLOAD_LIMIT = 2'd3;

   // Configuration reset values
   localparam logic [16:0] RST_TIMESTAMP_STEP = 17'd4500;
   localparam logic [31:0] RST_SYNC_SOURCE_ID = 32'd10;
   localparam logic [6:0] RST_PAYLOAD_KIND = 7'd96;
   localparam logic [11:0] RST_PAYLOAD_LIMIT = 12'd1400;

   typedef struct packed {
      logic [16:0] timestamp_step;
      logic [31:0] sync_source_id;
      logic [6:0]  payload_kind;
      logic [11:0] payload_limit;
   } cfg_type;

   // What the back end has to send for one input item
   typedef enum logic [1:0] {
      CMD_SINGLE,     // RTP header, then the NAL header byte (13 bytes)
      CMD_FRAG_START, // RTP header, FU indicator, FU header (14 bytes)
      CMD_DATA,       // one payload byte
      CMD_DATA_FRAG   // payload byte that closes a fragment, then next headers (15)
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic         data_end;
      logic         marker;
      logic [15:0]  seq;
      logic [31:0]  timestamp;
      logic [7:0]   fu_ind;
      logic [7:0]   fu_hdr;
   } cmd_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

>>> rtl/core/rtpk_if.sv
// Valid/ready channel interfaces for the packetizer's input and result items.
// No dependencies.

interface rtpk_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  nal_byte;
   logic [23:0] nal_length;
   logic        first_byte;

   modport source (output valid, nal_byte, nal_length, first_byte, input ready);
   modport sink (input valid, nal_byte, nal_length, first_byte, output ready);
endinterface

interface rtpk_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic       packet_end;
   logic       run_last;

   modport source (output valid, packet_byte, packet_end, run_last, input ready);
   modport sink (input valid, packet_byte, packet_end, run_last, output ready);
endinterface

>>> rtl/core/h264_rtp_packetizer.sv
// H.264 RTP packetizer: input bytes of a NAL unit in, RTP packet bytes out.
// Payload bytes pass at one per cycle. A unit's header byte yields 13 output
// bytes (single packet) or 14 (first FU-A fragment headers), and a byte that
// closes a fragment yields 15, so input stalls while those bytes drain. The
// output side sends one byte per cycle; a QUEUE_DEPTH-entry command queue
// between the front end (unit and fragment bookkeeping) and the back end
// (byte serializer) lets each side stall on its own. An accepted byte passes
// through the queue and the back end's output register before it is sent.
// Depends on rtpk_pkg, rtpk_if, rtpk_front, rtpk_queue, rtpk_back.

module h264_rtp_packetizer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   rtpk_req_if.sink    req_bus,
   rtpk_rsp_if.source  rsp_bus,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import rtpk_pkg::*;

   cfg_type    cfg_ff;
   cmd_type    push_cmd;
   cmd_type    head_cmd;
   q_stat_type q_stat;
   logic       push;
   logic       pop;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timestamp_step <= RST_TIMESTAMP_STEP;
         cfg_ff.sync_source_id <= RST_SYNC_SOURCE_ID;
         cfg_ff.payload_kind <= RST_PAYLOAD_KIND;
         cfg_ff.payload_limit <= RST_PAYLOAD_LIMIT;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TIMESTAMP_STEP: cfg_ff.timestamp_step <= csr_write_data[16:0];
            CSR_SYNC_SOURCE_ID: cfg_ff.sync_source_id <= csr_write_data;
            CSR_PAYLOAD_KIND:   cfg_ff.payload_kind <= csr_write_data[6:0];
            CSR_PAYLOAD_LIMIT:  cfg_ff.payload_limit <= csr_write_data[11:0];
            default:            cfg_ff <= cfg_ff;
         endcase
      end
   end

   rtpk_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .cfg    (cfg_ff),
      .q_stat (q_stat),
      .push   (push),
      .cmd    (push_cmd)
   );

   rtpk_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_stat   (q_stat)
   );

   rtpk_back u_back (
      .clock    (clock),
      .reset    (reset),
      .rsp      (rsp_bus),
      .cfg      (cfg_ff),
      .head_cmd (head_cmd),
      .q_stat   (q_stat),
      .pop      (pop)
   );

   // Queue is never written when full nor read when empty
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("command pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("command popped from an empty queue");

   // A new output item only appears when a command was waiting
   a_rsp_from_queue: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !$past(rsp_bus.valid)) |-> $past(!q_stat.empty))
      else $error("output item without a queued command");

endmodule

>>> rtl/core/rtpk_front.sv
// Front end: accepts NAL bytes, tracks unit/fragment state, pushes commands.
// Depends on rtpk_pkg and rtpk_req_if.

module rtpk_front (
   input  logic                clock,
   input  logic                reset,
   rtpk_req_if.sink            req,
   input  rtpk_pkg::cfg_type   cfg,
   input  rtpk_pkg::q_stat_type q_stat,
   output logic                push,
   output rtpk_pkg::cmd_type   cmd
);
   import rtpk_pkg::*;

   logic [15:0] seq_ff, seq_in;
   logic [31:0] ts_ff, ts_in;
   logic [7:0]  hdr_ff, hdr_in;
   logic [23:0] rem_ff, rem_in;
   logic [11:0] fill_ff, fill_in;
   logic        mode_ff, mode_in;

   logic        accept;
   logic [11:0] eff_limit;
   logic [23:0] len;
   logic [23:0] rem_first;
   logic [23:0] rem_dec;
   logic [11:0] fill_dec;
   logic        next_last;
   logic [15:0] seq_inc;
   logic [31:0] ts_step;

   assign req.ready = !q_stat.full;
   assign accept = req.valid && !q_stat.full;

   // Shared arithmetic
   assign eff_limit = (cfg.payload_limit < MIN_LIMIT) ? MIN_LIMIT : cfg.payload_limit;
   assign len = (req.nal_length == 24'd0) ? 24'd1 : req.nal_length;
   assign rem_first = len - 24'd1;
   assign rem_dec = rem_ff - 24'd1;
   assign fill_dec = (fill_ff != 12'd0) ? fill_ff - 12'd1 : 12'd0;
   assign next_last = rem_dec <= {12'd0, eff_limit};
   assign seq_inc = seq_ff + 16'd1;
   assign ts_step = ts_ff + {15'd0, cfg.timestamp_step};

   // Classify the item and build its command
   always_comb begin
      seq_in = seq_ff;
      ts_in = ts_ff;
      hdr_in = hdr_ff;
      rem_in = rem_ff;
      fill_in = fill_ff;
      mode_in = mode_ff;
      push = 1'b0;
      cmd.kind = CMD_DATA;
      cmd.data = req.nal_byte;
      cmd.data_end = 1'b0;
      cmd.marker = 1'b0;
      cmd.seq = seq_inc;
      cmd.timestamp = ts_ff;
      cmd.fu_ind = (hdr_ff & NAL_FNRI_MASK) | {3'd0, FU_A_TYPE};
      cmd.fu_hdr = hdr_ff & NAL_TYPE_MASK;
      if (accept && req.first_byte) begin
         push = 1'b1;
         ts_in = ts_step;
         hdr_in = req.nal_byte;
         rem_in = rem_first;
         cmd.timestamp = ts_step;
         seq_in = seq_inc;
         if (len <= {12'd0, eff_limit}) begin
            mode_in = 1'b0;
            fill_in = 12'd0;
            cmd.kind = CMD_SINGLE;
            cmd.marker = 1'b1;
            cmd.data_end = (rem_first == 24'd0);
         end else begin
            // first fragment never also ends the unit
            mode_in = 1'b1;
            cmd.kind = CMD_FRAG_START;
            cmd.fu_ind = (req.nal_byte & NAL_FNRI_MASK) | {3'd0, FU_A_TYPE};
            cmd.fu_hdr = 8'h80 | (req.nal_byte & NAL_TYPE_MASK);
            fill_in = (rem_first <= {12'd0, eff_limit}) ?
                      rem_first[11:0] - 12'd1 : eff_limit;
         end
      end else if (accept && rem_ff != 24'd0) begin
         push = 1'b1;
         rem_in = rem_dec;
         if (!mode_ff) begin
            cmd.data_end = (rem_dec == 24'd0);
         end else begin
            cmd.data_end = (fill_dec == 12'd0);
            fill_in = fill_dec;
            if (fill_dec == 12'd0 && rem_dec != 24'd0) begin
               // byte closes a fragment: open the next one
               cmd.kind = CMD_DATA_FRAG;
               cmd.marker = next_last;
               cmd.fu_hdr = (next_last ? 8'h40 : 8'h00) | (hdr_ff & NAL_TYPE_MASK);
               fill_in = next_last ? rem_dec[11:0] : eff_limit;
               seq_in = seq_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= '0;
         ts_ff <= '0;
         hdr_ff <= '0;
         rem_ff <= '0;
         fill_ff <= '0;
         mode_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in;
         ts_ff <= ts_in;
         hdr_ff <= hdr_in;
         rem_ff <= rem_in;
         fill_ff <= fill_in;
         mode_ff <= mode_in;
      end
   end

endmodule

>>> rtl/core/rtpk_queue.sv
// Small command queue between front and back ends.
// Depends on rtpk_pkg.

module rtpk_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rtpk_pkg::cmd_type    push_cmd,
   input  logic                 pop,
   output rtpk_pkg::cmd_type    head_cmd,
   output rtpk_pkg::q_stat_type q_stat
);
   import rtpk_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign q_stat.full = (count_ff == FULL_CNT);
   assign q_stat.empty = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/core/rtpk_back.sv
// Back end: expands each command into packet bytes, one per cycle while the receiver is ready.
// Depends on rtpk_pkg and rtpk_rsp_if.

module rtpk_back (
   input  logic                 clock,
   input  logic                 reset,
   rtpk_rsp_if.source           rsp,
   input  rtpk_pkg::cfg_type    cfg,
   input  rtpk_pkg::cmd_type    head_cmd,
   input  rtpk_pkg::q_stat_type q_stat,
   output logic                 pop
);
   import rtpk_pkg::*;

   logic [3:0] slot_ff, slot_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       end_ff, end_in;
   logic       last_ff, last_in;

   logic       advance;
   logic       emit;
   logic       lead;
   logic [3:0] hdr_pos;
   logic [3:0] last_slot;

   assign rsp.valid = valid_ff;
   assign rsp.packet_byte = byte_ff;
   assign rsp.packet_end = end_ff;
   assign rsp.run_last = last_ff;

   assign advance = !valid_ff || rsp.ready;
   assign emit = advance && !q_stat.empty;
   assign lead = (head_cmd.kind == CMD_DATA) || (head_cmd.kind == CMD_DATA_FRAG);
   assign hdr_pos = slot_ff - {3'd0, lead};

   // Number of bytes each command expands to, minus one
   always_comb begin
      case (head_cmd.kind)
         CMD_SINGLE:     last_slot = 4'd12;
         CMD_FRAG_START: last_slot = 4'd13;
         CMD_DATA:       last_slot = 4'd0;
         CMD_DATA_FRAG:  last_slot = 4'd14;
         default:        last_slot = 4'd0;
      endcase
   end

   assign pop = emit && (slot_ff == last_slot);

   // Byte selection for the current slot
   always_comb begin
      byte_in = 8'h00;
      end_in = 1'b0;
      if (lead && slot_ff == 4'd0) begin
         byte_in = head_cmd.data;
         end_in = head_cmd.data_end;
      end else begin
         case (hdr_pos)
            4'd0:  byte_in = RTP_VERSION_BYTE;
            4'd1:  byte_in = {head_cmd.marker, cfg.payload_kind};
            4'd2:  byte_in = head_cmd.seq[15:8];
            4'd3:  byte_in = head_cmd.seq[7:0];
            4'd4:  byte_in = head_cmd.timestamp[31:24];
            4'd5:  byte_in = head_cmd.timestamp[23:16];
            4'd6:  byte_in = head_cmd.timestamp[15:8];
            4'd7:  byte_in = head_cmd.timestamp[7:0];
            4'd8:  byte_in = cfg.sync_source_id[31:24];
            4'd9:  byte_in = cfg.sync_source_id[23:16];
            4'd10: byte_in = cfg.sync_source_id[15:8];
            4'd11: byte_in = cfg.sync_source_id[7:0];
            4'd12: begin
               if (head_cmd.kind == CMD_SINGLE) begin
                  byte_in = head_cmd.data;
                  end_in = head_cmd.data_end;
               end else begin
                  byte_in = head_cmd.fu_ind;
               end
            end
            4'd13: byte_in = head_cmd.fu_hdr;
            default: byte_in = 8'h00;
         endcase
      end
   end

   assign last_in = (slot_ff == last_slot);
   assign slot_in = pop ? 4'd0 : (emit ? slot_ff + 4'd1 : slot_ff);
   assign valid_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= byte_in;
         end_ff <= end_in;
         last_ff <= last_in;
      end
   end

endmodule

>>> verif/rtpk_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the H.264 RTP packetizer: predicts the packet bytes for each
// accepted NAL byte and compares them with the result channel.
// Depends on rtpk_pkg and rtpk_if.

module rtpk_checker (
   input  logic        clock,
   input  logic        reset,
   rtpk_req_if         req_mon,
   rtpk_rsp_if         rsp_mon,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data,
   output int unsigned fail_count,
   output int unsigned pending_count,
   output int unsigned nal_count,
   output int unsigned packet_count
);
   import rtpk_pkg::*;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       packet_end;
      logic       run_last;
   } rtp_beat_type;

   // Packet bytes predicted but not yet seen on the result channel
   rtp_beat_type rtp_beats_due[$];
   int unsigned  beats_this_item;

   // Shadow of the register file and the packetizer state
   cfg_type     cfg;
   logic [15:0] seq_num;
   logic [31:0] ts_now;
   logic [7:0]  nal_hdr;
   logic [23:0] nal_left;
   logic [11:0] frag_left;
   logic        frag_on;

   initial begin
      fail_count = 0;
      pending_count = 0;
      nal_count = 0;
      packet_count = 0;
   end

   // Limits below two bytes behave as two
   function automatic logic [11:0] limit_eff();
      return (cfg.payload_limit < MIN_LIMIT) ? MIN_LIMIT : cfg.payload_limit;
   endfunction

   task automatic push_beat(input logic [7:0] b, input logic e);
      rtp_beats_due.push_back('{packet_byte: b, packet_end: e, run_last: 1'b0});
      beats_this_item++;
   endtask

   // 12-byte RTP header; every packet takes the next sequence number
   task automatic put_rtp_header(input logic marker);
      seq_num = seq_num + 16'd1;
      packet_count++;
      push_beat(RTP_VERSION_BYTE, 1'b0);
      push_beat({marker, cfg.payload_kind}, 1'b0);
      push_beat(seq_num[15:8], 1'b0);
      push_beat(seq_num[7:0], 1'b0);
      push_beat(ts_now[31:24], 1'b0);
      push_beat(ts_now[23:16], 1'b0);
      push_beat(ts_now[15:8], 1'b0);
      push_beat(ts_now[7:0], 1'b0);
      push_beat(cfg.sync_source_id[31:24], 1'b0);
      push_beat(cfg.sync_source_id[23:16], 1'b0);
      push_beat(cfg.sync_source_id[15:8], 1'b0);
      push_beat(cfg.sync_source_id[7:0], 1'b0);
   endtask

   // FU-A fragment headers; the first fragment never carries the whole rest
   task automatic open_fragment(input logic is_first);
      logic [23:0] size;
      logic        is_last;
      size = (nal_left < {12'd0, limit_eff()}) ? nal_left : {12'd0, limit_eff()};
      if (is_first && size == nal_left)
         size = nal_left - 24'd1;
      is_last = (size == nal_left);
      put_rtp_header(is_last);
      push_beat((nal_hdr & NAL_FNRI_MASK) | {3'b000, FU_A_TYPE}, 1'b0);
      push_beat({is_first, is_last, 1'b0, 5'(nal_hdr & NAL_TYPE_MASK)}, 1'b0);
      frag_left = size[11:0];
   endtask

   task automatic predict_packet_bytes(input logic [7:0] b, input logic [23:0] len,
                                       input logic first);
      logic [23:0]  unit_len;
      logic         closes;
      rtp_beat_type tail;
      beats_this_item = 0;
      if (first) begin
         // new unit; one in progress is dropped
         unit_len = (len == 24'd0) ? 24'd1 : len;
         ts_now = ts_now + {15'd0, cfg.timestamp_step};
         nal_hdr = b;
         nal_left = unit_len - 24'd1;
         frag_left = '0;
         nal_count++;
         if (unit_len <= {12'd0, limit_eff()}) begin
            frag_on = 1'b0;
            put_rtp_header(1'b1);
            push_beat(b, nal_left == 24'd0);
         end else begin
            frag_on = 1'b1;
            open_fragment(1'b1);
         end
      end else if (nal_left != 24'd0) begin
         nal_left = nal_left - 24'd1;
         if (!frag_on) begin
            push_beat(b, nal_left == 24'd0);
         end else begin
            if (frag_left != 12'd0)
               frag_left = frag_left - 12'd1;
            closes = (frag_left == 12'd0);
            push_beat(b, closes);
            if (closes && nal_left != 24'd0)
               open_fragment(1'b0);
         end
      end
      // stray bytes outside a unit yield nothing
      if (beats_this_item != 0) begin
         tail = rtp_beats_due.pop_back();
         tail.run_last = 1'b1;
         rtp_beats_due.push_back(tail);
      end
   endtask

   always @(posedge clock) begin : watch
      rtp_beat_type want;
      if (reset) begin
         cfg.timestamp_step = RST_TIMESTAMP_STEP;
         cfg.sync_source_id = RST_SYNC_SOURCE_ID;
         cfg.payload_kind = RST_PAYLOAD_KIND;
         cfg.payload_limit = RST_PAYLOAD_LIMIT;
         seq_num = '0;
         ts_now = '0;
         nal_hdr = '0;
         nal_left = '0;
         frag_left = '0;
         frag_on = 1'b0;
         rtp_beats_due.delete();
      end else begin
         // register writes
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TIMESTAMP_STEP: cfg.timestamp_step = csr_write_data[16:0];
               CSR_SYNC_SOURCE_ID: cfg.sync_source_id = csr_write_data;
               CSR_PAYLOAD_KIND:   cfg.payload_kind = csr_write_data[6:0];
               CSR_PAYLOAD_LIMIT:  cfg.payload_limit = csr_write_data[11:0];
               default: ;
            endcase
         end

         // accepted input item
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            predict_packet_bytes(req_mon.nal_byte, req_mon.nal_length, req_mon.first_byte);

         // accepted result item
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (rtp_beats_due.size() == 0) begin
               $error("unexpected packet byte 0x%02h (end %0b, last %0b)",
                      rsp_mon.packet_byte, rsp_mon.packet_end, rsp_mon.run_last);
               fail_count++;
            end else begin
               want = rtp_beats_due.pop_front();
               if (rsp_mon.packet_byte !== want.packet_byte) begin
                  $error("packet_byte: expected 0x%02h, got 0x%02h",
                         want.packet_byte, rsp_mon.packet_byte);
                  fail_count++;
               end
               if (rsp_mon.packet_end !== want.packet_end) begin
                  $error("packet_end: expected %0b, got %0b",
                         want.packet_end, rsp_mon.packet_end);
                  fail_count++;
               end
               if (rsp_mon.run_last !== want.run_last) begin
                  $error("run_last: expected %0b, got %0b",
                         want.run_last, rsp_mon.run_last);
                  fail_count++;
               end
            end
         end
      end
      pending_count = rtp_beats_due.size();
   end

endmodule

>>> verif/tb_h264_rtp_packetizer.sv
`timescale 1ns / 100ps
// Top of the packetizer testbench: clock, reset, register writes, NAL byte
// stimulus and result back-pressure. Depends on rtpk_pkg, rtpk_if, rtpk_checker.

module tb_h264_rtp_packetizer;
   import rtpk_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 12;
   localparam int DRAIN_LIMIT = 50000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_TIMESTAMP_STEP;
   logic [31:0] csr_write_data = '0;

   rtpk_req_if req_bus();
   rtpk_rsp_if rsp_bus();

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned nal_count;
   int unsigned packet_count;

   logic        idle_on = 1'b0;
   logic        hold_request = 1'b0;
   int unsigned items_sent = 0;
   int unsigned cur_limit = 1400;

   h264_rtp_packetizer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   rtpk_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .nal_count        (nal_count),
      .packet_count     (packet_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly no gap, sometimes a short one, rarely a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else if (roll < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // One NAL byte; returns at the falling edge after it was taken
   task automatic send_item(input logic [7:0] b, input logic [23:0] len, input logic first);
      int unsigned gap;
      gap = idle_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.nal_byte = b;
      req_bus.nal_length = len;
      req_bus.first_byte = first;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
   endtask

   // Header byte plus sent-1 payload bytes; sent below the length cuts the unit
   task automatic send_unit(input logic [7:0] hdr, input logic [23:0] len,
                            input int unsigned sent);
      send_item(hdr, len, 1'b1);
      for (int unsigned i = 1; i < sent; i++)
         send_item(8'($urandom), 24'($urandom), 1'b0);
      items_sent += sent;
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Drain all results, let the pipeline empty, then load all four registers
   task automatic set_config(input logic [16:0] step, input logic [31:0] ssrc,
                             input logic [6:0] kind, input logic [11:0] limit);
      req_bus.valid = 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_csr(CSR_TIMESTAMP_STEP, 32'(step));
      write_csr(CSR_SYNC_SOURCE_ID, ssrc);
      write_csr(CSR_PAYLOAD_KIND, 32'(kind));
      write_csr(CSR_PAYLOAD_LIMIT, 32'(limit));
      cur_limit = (limit < MIN_LIMIT) ? 2 : limit;
   endtask

   task automatic random_unit();
      int unsigned pick;
      int unsigned len;
      int unsigned top_len;
      logic [7:0]  hdr;
      hdr = 8'($urandom);
      pick = $urandom_range(0, 99);
      top_len = (cur_limit > 40) ? 40 : cur_limit;
      if (pick >= 90) begin
         // unit cut short by the next header byte
         if (cur_limit > 40 || $urandom_range(0, 1) == 0) begin
            send_unit(hdr, 24'($urandom), $urandom_range(1, 6));
         end else begin
            len = $urandom_range(cur_limit + 2, cur_limit * 4 + 3);
            send_unit(hdr, 24'(len), $urandom_range(1, len - 1));
         end
      end else if (pick < 5) begin
         // byte outside any unit
         send_item(8'($urandom), 24'($urandom), 1'b0);
      end else if (pick < 35 || cur_limit > 40) begin
         len = $urandom_range(1, top_len);
         if (len == 1 && $urandom_range(0, 3) == 0)
            send_unit(hdr, 24'd0, 1);
         else
            send_unit(hdr, 24'(len), len);
      end else begin
         len = $urandom_range(cur_limit + 1, cur_limit * 4 + 3);
         send_unit(hdr, 24'(len), len);
      end
   endtask

   task automatic run_phase(input int unsigned target, input logic with_hold);
      int unsigned start;
      start = items_sent;
      if (with_hold) begin
         // result side stalls while a long fragmented unit keeps coming
         hold_request = 1'b1;
         send_unit(8'($urandom), 24'd40, 40);
      end
      while (items_sent - start < target)
         random_unit();
      // close the phase on a whole unit
      send_unit(8'($urandom), 24'd1, 1);
   endtask

   // Result side ready pattern
   initial begin
      int unsigned gap_left;
      int unsigned hold_left;
      gap_left = 0;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else if (gap_left != 0) begin
            rsp_bus.ready = 1'b0;
            gap_left--;
         end else if (idle_on) begin
            gap_left = pick_gap();
            rsp_bus.ready = (gap_left == 0);
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // Run limit
   initial begin
      #2000000;
      $display("tb_h264_rtp_packetizer: FAIL");
      $finish;
   end

   initial begin
      int unsigned drain;
      req_bus.valid = 1'b0;
      req_bus.nal_byte = '0;
      req_bus.nal_length = '0;
      req_bus.first_byte = 1'b0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset settings, one-byte units, zero length, stray byte
      send_unit(8'hff, 24'd1, 1);
      send_unit(8'h00, 24'd0, 1);
      send_item(8'h5a, 24'hffffff, 1'b0);

      // directed: all-ones registers, limit 0 behaves as 2
      set_config(17'h1ffff, 32'hffff_ffff, 7'h7f, 12'd0);
      send_unit(8'h65, 24'd2, 2);
      send_unit(8'he5, 24'd3, 3);
      send_unit(8'h7c, 24'd5, 5);
      send_unit(8'h9f, 24'hffffff, 4);
      send_unit(8'h41, 24'd1, 1);

      // directed: all-zero registers, limit 1 behaves as 2
      set_config(17'd0, 32'd0, 7'd0, 12'd1);
      send_unit(8'h1f, 24'd4, 4);
      send_unit(8'h80, 24'd1, 1);

      // random phases
      idle_on = 1'b1;
      set_config(17'd3000, $urandom, 7'd96, 12'd2);
      run_phase(80, 1'b0);

      idle_on = 1'b0;
      set_config(17'($urandom_range(0, 90000)), $urandom, 7'($urandom), 12'd3);
      run_phase(70, 1'b0);

      idle_on = 1'b1;
      set_config(17'd90000, $urandom, 7'($urandom), 12'd7);
      run_phase(50, 1'b1);

      set_config(17'h1ffff, $urandom, 7'($urandom), 12'd4095);
      run_phase(60, 1'b0);

      set_config(17'd1500, $urandom, 7'd96, 12'd5);
      run_phase(80, 1'b0);

      // wait for the last packet bytes
      req_bus.valid = 1'b0;
      drain = 0;
      while (pending_count != 0 && drain < DRAIN_LIMIT) begin
         @(negedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_count != 0)
         $error("%0d packet bytes never arrived", pending_count);

      $display("Sent %0d NAL bytes in %0d units, checked %0d RTP packets", items_sent,
               nal_count, packet_count);
      $display("Limits 2 to 4095, single and FU-A packets, cut units, stray bytes, stalls");
      if (fail_count == 0 && pending_count == 0)
         $display("tb_h264_rtp_packetizer: PASS");
      else
         $display("tb_h264_rtp_packetizer: FAIL");
      $finish;
   end

endmodule

>>> files.f
rtl/core/rtpk_pkg.sv
rtl/core/rtpk_if.sv
rtl/core/rtpk_front.sv
rtl/core/rtpk_queue.sv
rtl/core/rtpk_back.sv
rtl/core/h264_rtp_packetizer.sv
verif/rtpk_checker.sv
verif/tb_h264_rtp_packetizer.sv
